// File: design/sawtooth_tone_fir_generator_assert.svh
// assertion macros used by the checker file
`ifndef SAWTOOTH_TONE_FIR_GENERATOR_ASSERT_SVH
`define SAWTOOTH_TONE_FIR_GENERATOR_ASSERT_SVH

// next-cycle implication, suspended while reset is low
`define STFIR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stfir assertion failed");

// next-cycle implication, checked through reset as well
`define STFIR_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("stfir assertion failed");

`endif

// File: design/stfir_pkg.sv
package stfir_pkg;

  localparam int TAPS_DEF       = 8;
  localparam int BLINK_HALF_DEF = 48000;

  localparam int PHASE_W  = 24;
  localparam int STEP_W   = 21;
  localparam int AMP_W    = 15;
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = STEP_W;

  localparam int ACC_W   = 38;
  localparam int LO_W    = 19;
  localparam int HI_W    = ACC_W - LO_W;
  localparam int PLO_W   = LO_W + AMP_W;
  localparam int PHI_W   = HI_W + AMP_W + 1;
  localparam int SUM_W   = PHI_W + LO_W;
  localparam int FRAC_SH = 36;
  localparam int Q_W     = SUM_W - FRAC_SH;

  localparam logic [STEP_W-1:0] STEP_RST = STEP_W'(15729);
  localparam logic [AMP_W-1:0]  AMP_RST  = AMP_W'(16384);

  localparam logic signed [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1048576);
  localparam logic signed [PHASE_W-1:0] PHASE_TWO = PHASE_W'(2097152);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP = 2'd0,
    CFG_AMPLITUDE  = 2'd1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_RUN,
    ST_DRAIN,
    ST_SCALE,
    ST_SUM,
    ST_FIN
  } state_t;

  // symmetric lowpass taps, q0.16, taps past the eighth are zero
  function automatic logic [COEF_W-1:0] coef_of(input logic [3:0] k);
    logic [COEF_W-1:0] c;
    case (k)
      4'd0, 4'd7: c = COEF_W'(655);
      4'd1, 4'd6: c = COEF_W'(3277);
      4'd2, 4'd5: c = COEF_W'(7864);
      4'd3, 4'd4: c = COEF_W'(20972);
      default:    c = '0;
    endcase
    return c;
  endfunction

endpackage

// File: design/stfir_ram.sv
module stfir_ram #(
  parameter int DATA_W = 24,
  parameter int DEPTH  = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: design/sawtooth_tone_fir_generator.sv
// sawtooth tone source with an fir lowpass smoother
// input channel: one transaction per audio slot (in_valid, in_stall, in_slot_tick).
//   a transaction with in_slot_tick low is taken and changes nothing.
// result channel: one transaction per slot with the held sample and the led state.
// the sample is registered on acceptance: into the output register when that is
//   empty or being popped, else into the second buffer entry.
// every second slot also recomputes the held sample: one ring write, TAPS
//   ring reads through the single read port of the history memory feeding one
//   multiply-accumulate, a drain of the read and product registers, then scale,
//   sum and round states; the input is held off until the update returns to
//   idle.
// a two-entry output buffer lets a slot be taken while a result waits;
//   in_stall rises only when both entries are full or an update is running.
// reset (rst_n low, synchronous) clears phase, ring valid bits, held sample,
//   slot count and led, and loads the register defaults; ring entries read as
//   zero until written, so no clearing pass is needed. the user must make
//   configuration writes through cfg_we/cfg_index/cfg_wdata while idle; unchecked.
module sawtooth_tone_fir_generator #(
  parameter int TAPS       = stfir_pkg::TAPS_DEF,
  parameter int BLINK_HALF = stfir_pkg::BLINK_HALF_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [stfir_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [stfir_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_slot_tick,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [stfir_pkg::SAMPLE_W-1:0] out_sample_out,
  output logic                                 out_led_on
);

  import stfir_pkg::*;

  localparam int AW    = $clog2(TAPS);
  localparam int CNT_W = $clog2(2 * BLINK_HALF);
  localparam int PROD_W = COEF_W + 1 + PHASE_W;
  localparam logic [CNT_W:0] HALF_C = (CNT_W + 1)'(BLINK_HALF);
  localparam logic [CNT_W:0] FULL_C = (CNT_W + 1)'(2 * BLINK_HALF);
  localparam logic [AW-1:0] LAST_A = AW'(TAPS - 1);
  localparam logic signed [SUM_W-1:0] BIAS = SUM_W'((64'd1 << FRAC_SH) - 64'd1);
  localparam logic signed [Q_W-1:0] SAT_HI = Q_W'(32767);
  localparam logic signed [Q_W-1:0] SAT_LO = -Q_W'(32768);

  state_t state_r, state_nxt;

  logic [STEP_W-1:0] phase_step_r, phase_step_nxt;
  logic [AMP_W-1:0]  amp_r, amp_nxt;
  logic signed [PHASE_W-1:0] saw_phase_r, saw_phase_nxt;
  logic [AW-1:0]     wpos_r, wpos_nxt;
  logic signed [SAMPLE_W-1:0] held_r, held_nxt;
  logic [CNT_W-1:0]  slot_cnt_r, slot_cnt_nxt;
  logic              led_r, led_nxt;
  logic [TAPS-1:0]   ring_vld_r, ring_vld_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;
  logic              out_led_r, out_led_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  logic signed [SAMPLE_W-1:0] skid_sample_r, skid_sample_nxt;
  logic              skid_led_r, skid_led_nxt;

  logic [AW-1:0]     rd_addr_r, rd_addr_nxt;
  logic [AW-1:0]     iss_cnt_r, iss_cnt_nxt;
  logic              d_vld_r, d_vld_nxt;
  logic [AW-1:0]     d_k_r;
  logic              rd_vld_r;
  logic              p_vld_r;
  logic signed [ACC_W-1:0] prod_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [PLO_W-1:0]  p_lo_r;
  logic signed [PHI_W-1:0] p_hi_r;
  logic signed [SUM_W-1:0] sum_r;

  logic              ram_we;
  logic signed [PHASE_W-1:0] ram_rdata;
  logic signed [PHASE_W-1:0] tap_data;
  logic signed [PROD_W-1:0]  tap_prod;
  logic [COEF_W-1:0] coef_k;

  logic              in_take, tick, pop;
  logic [CNT_W:0]    cnt_inc;
  logic signed [PHASE_W-1:0] phase_sum;
  logic signed [SUM_W-1:0]   sum_biased;
  logic signed [Q_W-1:0]     q_val;

  stfir_ram #(
    .DATA_W(PHASE_W),
    .DEPTH (TAPS)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wpos_r),
    .wdata(saw_phase_r),
    .raddr(rd_addr_r),
    .rdata(ram_rdata)
  );

  assign in_stall = (state_r != ST_IDLE) || skid_valid_r;
  assign in_take  = in_valid && !in_stall;
  assign tick     = in_take && in_slot_tick;
  assign pop      = out_valid_r && !out_stall;
  assign cnt_inc  = {1'b0, slot_cnt_r} + (CNT_W + 1)'(1);
  assign phase_sum = saw_phase_r + $signed({{(PHASE_W - STEP_W){1'b0}}, phase_step_r});

  assign tap_data = rd_vld_r ? ram_rdata : '0;
  assign coef_k   = coef_of(4'(d_k_r));
  assign tap_prod = $signed({1'b0, coef_k}) * tap_data;

  assign sum_biased = sum_r + (sum_r[SUM_W-1] ? BIAS : '0);
  assign q_val      = sum_biased[SUM_W-1:FRAC_SH];

  always_comb begin
    state_nxt       = state_r;
    phase_step_nxt  = phase_step_r;
    amp_nxt         = amp_r;
    saw_phase_nxt   = saw_phase_r;
    wpos_nxt        = wpos_r;
    held_nxt        = held_r;
    slot_cnt_nxt    = slot_cnt_r;
    led_nxt         = led_r;
    ring_vld_nxt    = ring_vld_r;
    out_valid_nxt   = out_valid_r;
    out_sample_nxt  = out_sample_r;
    out_led_nxt     = out_led_r;
    skid_valid_nxt  = skid_valid_r;
    skid_sample_nxt = skid_sample_r;
    skid_led_nxt    = skid_led_r;
    rd_addr_nxt     = rd_addr_r;
    iss_cnt_nxt     = iss_cnt_r;
    d_vld_nxt       = 1'b0;
    acc_nxt         = p_vld_r ? acc_r + prod_r : acc_r;
    ram_we          = 1'b0;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_PHASE_STEP: phase_step_nxt = cfg_wdata[STEP_W-1:0];
        CFG_AMPLITUDE:  amp_nxt = cfg_wdata[AMP_W-1:0];
        default: ;
      endcase
    end

    // slot count and led
    if (tick) begin
      if (cnt_inc == HALF_C) begin
        led_nxt      = 1'b0;
        slot_cnt_nxt = cnt_inc[CNT_W-1:0];
      end else if (cnt_inc >= FULL_C) begin
        led_nxt      = 1'b1;
        slot_cnt_nxt = '0;
      end else begin
        slot_cnt_nxt = cnt_inc[CNT_W-1:0];
      end
    end

    // two-entry output buffer
    if (skid_valid_r) begin
      if (pop) begin
        out_sample_nxt = skid_sample_r;
        out_led_nxt    = skid_led_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (tick) begin
      if (out_valid_r && !pop) begin
        skid_valid_nxt  = 1'b1;
        skid_sample_nxt = held_r;
        skid_led_nxt    = led_nxt;
      end else begin
        out_valid_nxt  = 1'b1;
        out_sample_nxt = held_r;
        out_led_nxt    = led_nxt;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (tick && slot_cnt_r[0]) begin
          saw_phase_nxt = (phase_sum > PHASE_ONE) ? phase_sum - PHASE_TWO : phase_sum;
          state_nxt     = ST_WRITE;
        end
      end
      ST_WRITE: begin
        ram_we               = 1'b1;
        ring_vld_nxt[wpos_r] = 1'b1;
        rd_addr_nxt          = wpos_r;
        iss_cnt_nxt          = '0;
        wpos_nxt             = (wpos_r == LAST_A) ? '0 : wpos_r + AW'(1);
        acc_nxt              = '0;
        state_nxt            = ST_RUN;
      end
      ST_RUN: begin
        d_vld_nxt   = 1'b1;
        rd_addr_nxt = (rd_addr_r == LAST_A) ? '0 : rd_addr_r + AW'(1);
        iss_cnt_nxt = iss_cnt_r + AW'(1);
        if (iss_cnt_r == LAST_A) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!d_vld_r && !p_vld_r) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (q_val > SAT_HI) begin
          held_nxt = SAT_HI[SAMPLE_W-1:0];
        end else if (q_val < SAT_LO) begin
          held_nxt = SAT_LO[SAMPLE_W-1:0];
        end else begin
          held_nxt = q_val[SAMPLE_W-1:0];
        end
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      phase_step_r <= STEP_RST;
      amp_r        <= AMP_RST;
      saw_phase_r  <= '0;
      wpos_r       <= '0;
      held_r       <= '0;
      slot_cnt_r   <= '0;
      led_r        <= 1'b0;
      ring_vld_r   <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
      d_vld_r      <= 1'b0;
      p_vld_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_step_r <= phase_step_nxt;
      amp_r        <= amp_nxt;
      saw_phase_r  <= saw_phase_nxt;
      wpos_r       <= wpos_nxt;
      held_r       <= held_nxt;
      slot_cnt_r   <= slot_cnt_nxt;
      led_r        <= led_nxt;
      ring_vld_r   <= ring_vld_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      d_vld_r      <= d_vld_nxt;
      p_vld_r      <= d_vld_r;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    out_sample_r  <= out_sample_nxt;
    out_led_r     <= out_led_nxt;
    skid_sample_r <= skid_sample_nxt;
    skid_led_r    <= skid_led_nxt;
    rd_addr_r     <= rd_addr_nxt;
    iss_cnt_r     <= iss_cnt_nxt;
    d_k_r         <= iss_cnt_r;
    rd_vld_r      <= ring_vld_r[rd_addr_r];
    prod_r        <= $signed(tap_prod[ACC_W-1:0]);
    acc_r         <= acc_nxt;
    p_lo_r        <= PLO_W'(acc_r[LO_W-1:0]) * PLO_W'(amp_r);
    p_hi_r        <= PHI_W'($signed(acc_r[ACC_W-1:LO_W])) * $signed({1'b0, amp_r});
    sum_r         <= ($signed({{(SUM_W - PHI_W){p_hi_r[PHI_W-1]}}, p_hi_r}) <<< LO_W)
                     + $signed({{(SUM_W - PLO_W){1'b0}}, p_lo_r});
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_led_on     = out_led_r;

endmodule

// File: design/stfir_checker.sv
`include "sawtooth_tone_fir_generator_assert.svh"

module stfir_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_slot_tick,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_sample_out,
  input logic        out_led_on
);

  `STFIR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `STFIR_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_sample_out) && $stable(out_led_on))
  `STFIR_ASSERT_NEXT(a_tick_result, clk, rst_n, in_valid && !in_stall && in_slot_tick, out_valid)
  `STFIR_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)

endmodule

bind sawtooth_tone_fir_generator stfir_checker u_stfir_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_slot_tick  (in_slot_tick),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_sample_out(out_sample_out),
  .out_led_on    (out_led_on)
);

// File: dv/testbench.sv
module testbench;
  import stfir_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int IDLE_PCT       = 19;
  localparam int RANDOM_SLOTS   = 1800;
  localparam int PHASES         = 10;
  localparam int HOLD_CYCLES    = 300;
  localparam int LED_SLOTS      = 40;
  localparam int SAMPLE_MAX     = 2 ** (SAMPLE_W - 1) - 1;
  localparam int SAMPLE_MIN     = -(2 ** (SAMPLE_W - 1));
  localparam int BLINK_WRAP     = 2 * BLINK_HALF_DEF;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam logic [STEP_W-1:0]    STEP_MAX    = '1;
  localparam logic [STEP_W-1:0]    STEP_UNITY  = STEP_W'(1048576);
  localparam logic [AMP_W-1:0]     AMP_MAX     = '1;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       led;
  } slot_result_t;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [CFG_IDX_W-1:0]          cfg_index;
  logic [CFG_DATA_W-1:0]         cfg_wdata;
  logic                          in_valid;
  logic                          in_stall;
  logic                          in_slot_tick;
  logic                          out_valid;
  logic                          out_stall;
  logic signed [SAMPLE_W-1:0]    out_sample_out;
  logic                          out_led_on;

  // tone model state
  logic [STEP_W-1:0]             tone_step;
  logic [AMP_W-1:0]              tone_amp;
  logic signed [PHASE_W-1:0]     saw_acc;
  logic signed [PHASE_W-1:0]     phase_hist [TAPS_DEF];
  int                            hist_wr;
  int                            tap_coef [TAPS_DEF];
  logic signed [SAMPLE_W-1:0]    held_out;
  logic [16:0]                   slot_num;
  logic                          led_lit;

  slot_result_t                  pending_samples [$];
  slot_result_t                  want;

  bit                            gaps_on;
  int                            hold_left;
  int                            stuck_cycles;
  int                            mismatches;
  int                            results_checked;
  int                            slots_sent;
  int                            empty_slots_sent;
  int                            phase_updates;
  int                            cfg_writes;
  int                            led_lit_results;

  sawtooth_tone_fir_generator dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_slot_tick  (in_slot_tick),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample_out(out_sample_out),
    .out_led_on    (out_led_on)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic reset_tone_model();
    tone_step = STEP_RST;
    tone_amp  = AMP_RST;
    saw_acc   = '0;
    for (int k = 0; k < TAPS_DEF; k++) begin
      phase_hist[k] = '0;
    end
    tap_coef[0] = 655;
    tap_coef[1] = 3277;
    tap_coef[2] = 7864;
    tap_coef[3] = 20972;
    tap_coef[4] = 20972;
    tap_coef[5] = 7864;
    tap_coef[6] = 3277;
    tap_coef[7] = 655;
    hist_wr  = 0;
    held_out = '0;
    slot_num = '0;
    led_lit  = 1'b0;
  endtask

  function automatic slot_result_t tone_predict_slot();
    slot_result_t r;
    int           p;
    int           k;
    longint       acc;
    longint       scaled;
    r.sample = held_out;
    if (slot_num[0]) begin
      phase_updates++;
      p = int'(saw_acc) + int'(tone_step);
      if (p > int'(PHASE_ONE)) begin
        p = p - int'(PHASE_TWO);
      end
      saw_acc = p[PHASE_W-1:0];
      phase_hist[hist_wr] = saw_acc;
      acc = 0;
      for (k = 0; k < TAPS_DEF; k++) begin
        acc += longint'(tap_coef[k]) * longint'(phase_hist[(hist_wr + k) % TAPS_DEF]);
      end
      hist_wr = (hist_wr + 1) % TAPS_DEF;
      scaled = (acc * longint'(tone_amp)) / (longint'(1) << FRAC_SH);
      if (scaled > SAMPLE_MAX) begin
        scaled = SAMPLE_MAX;
      end
      if (scaled < SAMPLE_MIN) begin
        scaled = SAMPLE_MIN;
      end
      held_out = scaled[SAMPLE_W-1:0];
    end
    slot_num = slot_num + 1'b1;
    if (slot_num == 17'(BLINK_HALF_DEF)) begin
      led_lit = 1'b0;
    end else if (slot_num >= 17'(BLINK_WRAP)) begin
      led_lit  = 1'b1;
      slot_num = '0;
    end
    r.led = led_lit;
    return r;
  endfunction

  task automatic send_slot(input logic tick);
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_slot_tick <= tick;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    if (tick) begin
      pending_samples.push_back(tone_predict_slot());
      slots_sent++;
    end else begin
      empty_slots_sent++;
    end
    @(negedge clk);
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == CFG_PHASE_STEP) begin
      tone_step = data[STEP_W-1:0];
    end else if (idx == CFG_AMPLITUDE) begin
      tone_amp = data[AMP_W-1:0];
    end
    cfg_writes++;
  endtask

  task automatic test_reset_defaults();
    send_slot(1'b1);
    send_slot(1'b0);
    send_slot(1'b1);
    send_slot(1'b1);
    send_slot(1'b0);
    send_slot(1'b1);
  endtask

  task automatic test_register_extremes();
    logic [CFG_DATA_W-1:0] noisy_amp;
    settle_block();
    // upper data bits above the amplitude width must be dropped
    noisy_amp = '1;
    noisy_amp[AMP_W-1:0] = AMP_MAX;
    cfg_write(CFG_PHASE_STEP, '0);
    cfg_write(CFG_AMPLITUDE, noisy_amp);
    repeat (3) send_slot(1'b1);
    settle_block();
    // phase step of exactly 1.0, the wrap point of the sawtooth
    cfg_write(CFG_PHASE_STEP, CFG_DATA_W'(STEP_UNITY));
    repeat (5) send_slot(1'b1);
    settle_block();
    cfg_write(CFG_PHASE_STEP, CFG_DATA_W'(STEP_MAX));
    cfg_write(CFG_SPARE_A, '1);
    cfg_write(CFG_SPARE_B, '0);
    repeat (5) send_slot(1'b1);
    settle_block();
    cfg_write(CFG_AMPLITUDE, '0);
    send_slot(1'b1);
    send_slot(1'b0);
    send_slot(1'b1);
    send_slot(1'b1);
  endtask

  task automatic test_random_slots();
    logic [STEP_W-1:0]     step_v;
    logic [AMP_W-1:0]      amp_v;
    logic [CFG_DATA_W-1:0] data_v;
    logic                  tick;
    int                    counted;
    for (int ph = 0; ph < PHASES; ph++) begin
      settle_block();
      case ($urandom_range(7))
        0:       step_v = '0;
        1:       step_v = STEP_MAX;
        2:       step_v = STEP_UNITY;
        3, 4:    step_v = STEP_W'($urandom_range(60000));
        default: step_v = STEP_W'($urandom);
      endcase
      case ($urandom_range(5))
        0:       amp_v = '0;
        1:       amp_v = AMP_MAX;
        default: amp_v = AMP_W'($urandom);
      endcase
      data_v = CFG_DATA_W'($urandom);
      data_v[AMP_W-1:0] = amp_v;
      cfg_write(CFG_PHASE_STEP, CFG_DATA_W'(step_v));
      cfg_write(CFG_AMPLITUDE, data_v);
      if ($urandom_range(3) == 0) begin
        cfg_write($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, CFG_DATA_W'($urandom));
      end
      gaps_on = (ph != PHASES / 2);
      counted = 0;
      while (counted < RANDOM_SLOTS / PHASES) begin
        tick = ($urandom_range(9) != 0);
        send_slot(tick);
        counted++;
      end
      gaps_on = 1'b1;
    end
  endtask

  task automatic test_output_backpressure();
    settle_block();
    gaps_on   = 1'b0;
    hold_left = HOLD_CYCLES;
    repeat (30) send_slot(1'b1);
    gaps_on = 1'b1;
  endtask

  task automatic test_led_blink();
    settle_block();
    cfg_write(CFG_PHASE_STEP, CFG_DATA_W'(STEP_RST));
    cfg_write(CFG_AMPLITUDE, CFG_DATA_W'(AMP_MAX));
    // unbroken run of slots, led stays dark this far from the full blink period
    gaps_on = 1'b0;
    repeat (LED_SLOTS) send_slot(1'b1);
    gaps_on = 1'b1;
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= gaps_on && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: unexpected transaction sample=%0d led=%0b",
                   out_sample_out, out_led_on);
        end
      end else begin
        want = pending_samples.pop_front();
        if (out_sample_out !== want.sample) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: result %0d sample_out expected %0d actual %0d",
                     results_checked, want.sample, out_sample_out);
          end
        end
        if (out_led_on !== want.led) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: result %0d led_on expected %0b actual %0b",
                     results_checked, want.led, out_led_on);
          end
        end
        if (out_led_on === 1'b1) begin
          led_lit_results++;
        end
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_PHASE_STEP;
    cfg_wdata        = '0;
    in_valid         = 1'b0;
    in_slot_tick     = 1'b0;
    gaps_on          = 1'b1;
    hold_left        = 0;
    stuck_cycles     = 0;
    mismatches       = 0;
    results_checked  = 0;
    slots_sent       = 0;
    empty_slots_sent = 0;
    phase_updates    = 0;
    cfg_writes       = 0;
    led_lit_results  = 0;
    reset_tone_model();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_register_extremes();
    test_random_slots();
    test_output_backpressure();
    test_led_blink();
    settle_block();

    mismatches += pending_samples.size();
    $display("run covered %0d audio slots and %0d empty ones, %0d phase updates, %0d reg writes",
             slots_sent, empty_slots_sent, phase_updates, cfg_writes);
    $display("%0d results checked, %0d with the led lit, %0d mismatches",
             results_checked, led_lit_results, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
